FILE: rtl/spus_pkg.sv
// Shared types, sizes and helper functions for the superpixel undersegmentation score block.
// It depends on nothing. Every module of the block imports it.
package spus_pkg;

  // Sizes of the histogram and of the counters.
  localparam int NUM_LABELS = 256;
  localparam int COUNT_BITS = 16;
  localparam int LABEL_W    = 8;
  localparam int OUT_W      = 16;
  localparam int SUM_W      = 24;
  localparam int IDX_W      = (NUM_LABELS > 1) ? $clog2(NUM_LABELS) : 1;

  // The shared adder runs at the width of the running sums, which also covers the counters.
  localparam int ALU_W = (SUM_W > COUNT_BITS) ? SUM_W : COUNT_BITS;

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [SUM_W-1:0]      sum_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [ALU_W-1:0]      alu_word_t;
  typedef logic [LABEL_W-1:0]    label_t;
  typedef logic [OUT_W-1:0]      out_cnt_t;

  // Saturation limits, given at the width of the shared adder.
  localparam alu_word_t CNT_LIMIT = ALU_W'((64'd1 << COUNT_BITS) - 64'd1);
  localparam alu_word_t SUM_LIMIT = ALU_W'((64'd1 << SUM_W) - 64'd1);

  // Operations of the shared adder.
  typedef enum logic {
    ALU_ADD_SAT,
    ALU_SUB
  } alu_op_t;

  // One request to the shared adder.
  typedef struct packed {
    alu_op_t   op;
    alu_word_t a;
    alu_word_t b;
    alu_word_t lim;
  } alu_req_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SIZE,
    S_BIN,
    S_LEAK,
    S_ACC,
    S_LKS
  } state_t;

  // Histogram port controls from the sequencer.
  typedef struct packed {
    logic rd_en;
    idx_t rd_addr;
    logic wr_en;
    idx_t wr_addr;
    cnt_t wr_data;
    logic clr_all;
  } hist_ctl_t;

  localparam int EXT_W = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;

  // Clip a counter to the 16-bit output fields.
  function automatic out_cnt_t clip_out(cnt_t v);
    logic [EXT_W-1:0] e;
    e = EXT_W'(v);
    if (e > EXT_W'((64'd1 << OUT_W) - 64'd1)) begin
      return '1;
    end
    return e[OUT_W-1:0];
  endfunction

endpackage

FILE: rtl/spus_alu.sv
// Shared arithmetic unit: saturating add and plain subtract.
// Depends on spus_pkg for the request type and word width.
module spus_alu (
  input  spus_pkg::alu_req_t  req,
  output spus_pkg::alu_word_t res
);
  import spus_pkg::*;

  logic [ALU_W:0] sum_ext;

  // One wide add with a compare against the limit, or one subtract.
  always_comb begin
    sum_ext = {1'b0, req.a} + {1'b0, req.b};
    case (req.op)
      ALU_ADD_SAT: begin
        res = (sum_ext > {1'b0, req.lim}) ? req.lim : sum_ext[ALU_W-1:0];
      end
      ALU_SUB: begin
        res = req.a - req.b;
      end
      default: begin
        res = req.a;
      end
    endcase
  end

endmodule

FILE: rtl/spus_hist.sv
// Label histogram: one memory of bin counts with a registered read port and one write port.
// Depends on spus_pkg. Per-bin valid flags make a cleared bin read as zero.
module spus_hist (
  input  logic                clk,
  input  logic                rst_n,
  input  spus_pkg::hist_ctl_t ctl,
  output spus_pkg::cnt_t      rd_data
);
  import spus_pkg::*;

  cnt_t                  mem [NUM_LABELS];
  logic [NUM_LABELS-1:0] vld_r;
  cnt_t                  rd_data_r;
  logic                  rd_vld_r;

  // Bin storage, written and read in the same clocked block.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[ctl.rd_addr];
    end
  end

  // Valid flags; a clear drops all of them at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctl.clr_all) begin
        vld_r <= '0;
      end else if (ctl.wr_en) begin
        vld_r[ctl.wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_vld_r <= vld_r[ctl.rd_addr];
      end
    end
  end

  // A bin not written since the last clear reads as zero.
  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

FILE: rtl/superpixel_undersegmentation_score_top.sv
// Top level of the superpixel undersegmentation score block: sequencer, counters, output register.
// Depends on spus_pkg, spus_alu and spus_hist.
//
// Pixels arrive one item at a time as a ground-truth label and a last-pixel flag. A pixel that
// does not end its superpixel goes through acceptance with histogram read, size increment and bin
// update, because the size, the bin and both running sums all go through one shared saturating
// adder. A superpixel's last pixel also goes through the leak subtract and both sum updates, held
// at the last while a previous result still waits in the output register; it then delivers one
// result item with the largest overlap, the leaked pixel count and the two running sums. The
// histogram is cleared at once through per-bin valid flags, so there is no clearing pass after
// reset or between superpixels. Labels at or above the histogram size count toward the size only.
module superpixel_undersegmentation_score_top (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  spus_pkg::label_t         in_ground_label,
  input  logic                     in_last_pixel,
  output logic                     out_valid,
  input  logic                     out_stall,
  output spus_pkg::out_cnt_t       out_max_overlap,
  output spus_pkg::out_cnt_t       out_leaked_pixels,
  output spus_pkg::sum_t           out_accuracy_total,
  output spus_pkg::sum_t           out_leakage_total
);
  import spus_pkg::*;

  state_t    state_r, state_nxt;
  idx_t      idx_r, idx_nxt;
  logic      in_rng_r, in_rng_nxt;
  logic      last_r, last_nxt;
  cnt_t      size_r, size_nxt;
  cnt_t      best_r, best_nxt;
  cnt_t      leak_r, leak_nxt;
  sum_t      acc_r, acc_nxt;
  sum_t      lks_r, lks_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_cnt_t  out_max_r, out_leak_r;
  sum_t      out_acc_r, out_lks_r;
  logic      out_load;
  logic      in_acc;
  logic      out_free;
  alu_req_t  alu_req;
  alu_word_t alu_res;
  hist_ctl_t hist_ctl;
  cnt_t      hist_rd;
  cnt_t      bin_new;

  spus_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  spus_hist u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (hist_ctl),
    .rd_data (hist_rd)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign bin_new  = alu_res[COUNT_BITS-1:0];

  // Sequencer: next state, shared adder requests and histogram controls.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    in_rng_nxt    = in_rng_r;
    last_nxt      = last_r;
    size_nxt      = size_r;
    best_nxt      = best_r;
    leak_nxt      = leak_r;
    acc_nxt       = acc_r;
    lks_nxt       = lks_r;
    out_load      = 1'b0;
    alu_req.op    = ALU_ADD_SAT;
    alu_req.a     = '0;
    alu_req.b     = '0;
    alu_req.lim   = CNT_LIMIT;
    hist_ctl         = '0;
    hist_ctl.rd_addr = IDX_W'(in_ground_label);
    hist_ctl.wr_addr = idx_r;
    hist_ctl.wr_data = bin_new;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          hist_ctl.rd_en = 1'b1;
          idx_nxt        = IDX_W'(in_ground_label);
          in_rng_nxt     = (32'(in_ground_label) < 32'(NUM_LABELS));
          last_nxt       = in_last_pixel;
          state_nxt      = S_SIZE;
        end
      end
      S_SIZE: begin
        alu_req.a = ALU_W'(size_r);
        alu_req.b = ALU_W'(1);
        size_nxt  = alu_res[COUNT_BITS-1:0];
        state_nxt = S_BIN;
      end
      S_BIN: begin
        // Increment the bin read at acceptance; the bin just written is the only new candidate.
        alu_req.a = ALU_W'(hist_rd);
        alu_req.b = ALU_W'(1);
        if (in_rng_r) begin
          hist_ctl.wr_en = 1'b1;
          if (bin_new > best_r) begin
            best_nxt = bin_new;
          end
        end
        state_nxt = last_r ? S_LEAK : S_IDLE;
      end
      S_LEAK: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = ALU_W'(size_r);
        alu_req.b  = ALU_W'(best_r);
        leak_nxt   = alu_res[COUNT_BITS-1:0];
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        alu_req.a   = ALU_W'(acc_r);
        alu_req.b   = ALU_W'(best_r);
        alu_req.lim = SUM_LIMIT;
        acc_nxt     = alu_res[SUM_W-1:0];
        state_nxt   = S_LKS;
      end
      S_LKS: begin
        // Finish the leakage sum once the output register can take the result.
        alu_req.a   = ALU_W'(lks_r);
        alu_req.b   = ALU_W'(leak_r);
        alu_req.lim = SUM_LIMIT;
        if (out_free) begin
          lks_nxt          = alu_res[SUM_W-1:0];
          out_load         = 1'b1;
          hist_ctl.clr_all = 1'b1;
          size_nxt         = '0;
          best_nxt         = '0;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output valid holds while the result is stalled.
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  // Control state and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= '0;
      best_r      <= '0;
      acc_r       <= '0;
      lks_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      best_r      <= best_nxt;
      acc_r       <= acc_nxt;
      lks_r       <= lks_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item fields and the output register.
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    in_rng_r <= in_rng_nxt;
    last_r   <= last_nxt;
    leak_r   <= leak_nxt;
    if (out_load) begin
      out_max_r  <= clip_out(best_r);
      out_leak_r <= clip_out(leak_r);
      out_acc_r  <= acc_r;
      out_lks_r  <= alu_res[SUM_W-1:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_max_overlap    = out_max_r;
  assign out_leaked_pixels  = out_leak_r;
  assign out_accuracy_total = out_acc_r;
  assign out_leakage_total  = out_lks_r;

endmodule

FILE: rtl/spus_checker.sv
// Port-level checks for the superpixel undersegmentation score block, and their binding.
// Depends on spus_pkg and the top level's ports.
module spus_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input spus_pkg::out_cnt_t  out_max_overlap,
  input spus_pkg::out_cnt_t  out_leaked_pixels,
  input spus_pkg::sum_t      out_accuracy_total,
  input spus_pkg::sum_t      out_leakage_total
);
  import spus_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // The block is busy in the cycle after it takes an item.
  a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block ready right after taking an item");

  // A new result appears only at the end of busy work.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

  // The running sums include the current superpixel's values.
  a_sums_cover: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_accuracy_total >= SUM_W'(out_max_overlap)) &&
                  (out_leakage_total >= SUM_W'(out_leaked_pixels)))
    else $error("running sum below its latest term");

endmodule

bind superpixel_undersegmentation_score_top spus_checker u_spus_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_max_overlap    (out_max_overlap),
  .out_leaked_pixels  (out_leaked_pixels),
  .out_accuracy_total (out_accuracy_total),
  .out_leakage_total  (out_leakage_total)
);
